@@ src/fra_pkg.sv @@
// Shared constants and control/status types for the Fenwick range-add block.
`default_nettype none

package fra_pkg;

    // Built capacity of the trees and widths fixed by the item format.
    localparam int              FRA_MAX_POSITIONS = 1024;
    localparam int              POS_W             = 11;
    localparam int              DATA_W            = 64;
    localparam logic [POS_W-1:0] SIZE_RESET       = 11'd1024;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_en;     // write zero at the clearing address, then advance it
        logic load_req;   // capture the request payload
        logic ld_first;   // set up the walk from the first position
        logic ld_second;  // set up the cancelling walk after the last position
        logic ld_query;   // set up the query walk and clear the accumulators
        logic walk_up;    // one update walk step (read, write back the node before)
        logic walk_down;  // one query walk step (read, accumulate the node before)
        logic ld_prod;    // capture (x+1) times the difference prefix
        logic out_load;   // load the result register
    } fra_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;    // last entry of the clearing pass is being written
        logic is_query;    // captured request is a query
        logic bad_req;     // captured update has an invalid range
        logic need_second; // last position lies below the effective size
        logic up_more;     // update walk position is still inside 1..n
        logic down_more;   // query walk position is still nonzero
    } fra_status_t;

endpackage

`default_nettype wire

@@ src/fra_req_if.sv @@
// Request channel: operation mode, add range and value.
`default_nettype none

interface fra_req_if;
    import fra_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic [POS_W-1:0]         first_pos;
    logic [POS_W-1:0]         last_pos;
    logic signed [DATA_W-1:0] add_value;

    modport source (output valid, output mode, output first_pos, output last_pos,
                    output add_value, input ready);
    modport sink (input valid, input mode, input first_pos, input last_pos,
                  input add_value, output ready);
endinterface

`default_nettype wire

@@ src/fra_rsp_if.sv @@
// Response channel: prefix sum and bad-request flag.
`default_nettype none

interface fra_rsp_if;
    import fra_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] prefix_sum;
    logic                     bad_request;

    modport source (output valid, output prefix_sum, output bad_request, input ready);
    modport sink (input valid, input prefix_sum, input bad_request, output ready);
endinterface

`default_nettype wire

@@ src/fra_cfg_if.sv @@
// Configuration write channel for the size register.
`default_nettype none

interface fra_cfg_if;
    import fra_pkg::*;

    logic             valid;
    logic             ready;
    logic [POS_W-1:0] size_in_use;

    modport source (output valid, output size_in_use, input ready);
    modport sink (input valid, input size_in_use, output ready);
endinterface

`default_nettype wire

@@ src/fenwick_range_add_prefix_sum.sv @@
// Fenwick range-add / prefix-sum block: top level joining controller and datapath.
// A range add walks the trees from the first position and then from the one after the last,
// skipping the second walk when the range reaches the size; a query walks down once; a rejected
// update walks nothing. A walk visits at most 11 nodes at 1024 positions, one node per cycle
// through the RAM read port with the write-back overlapped. The next request is taken in the
// cycle after a result is loaded. After reset a clearing pass zeroes both trees before requests.
`default_nettype none

module fenwick_range_add_prefix_sum
    import fra_pkg::*;
#(
    parameter int MAX_POSITIONS = FRA_MAX_POSITIONS
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    fra_cfg_if.sink    cfg,
    fra_req_if.sink    req,
    fra_rsp_if.source  rsp
);

    fra_cmd_t    cmd;
    fra_status_t status;
    logic [DATA_W-1:0] prefix_bits;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    fra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    fra_datapath #(
        .MAX_POSITIONS (MAX_POSITIONS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg.valid),
        .cfg_size    (cfg.size_in_use),
        .req_mode    (req.mode),
        .req_first   (req.first_pos),
        .req_last    (req.last_pos),
        .req_value   (req.add_value),
        .cmd         (cmd),
        .status      (status),
        .prefix_sum  (prefix_bits),
        .bad_request (rsp.bad_request)
    );

    assign rsp.prefix_sum = prefix_bits;

endmodule

`default_nettype wire

@@ src/fra_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module fra_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ src/fra_ctrl.sv @@
// Controller state machine sequencing the clearing pass, tree walks and results.
`default_nettype none

module fra_ctrl
    import fra_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  wire fra_status_t status,
    output fra_cmd_t         cmd
);

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_DECIDE = 9'b000000100,
        S_WALK1  = 9'b000001000,
        S_PREP2  = 9'b000010000,
        S_WALK2  = 9'b000100000,
        S_QWALK  = 9'b001000000,
        S_MUL    = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (status.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (status.is_query)
                begin
                    cmd.ld_query = 1'b1;
                    state_next   = S_QWALK;
                end
                else if (status.bad_req)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.ld_first = 1'b1;
                    state_next   = S_WALK1;
                end
            end
            S_WALK1:
            begin
                cmd.walk_up = 1'b1;
                if (!status.up_more)
                begin
                    state_next = status.need_second ? S_PREP2 : S_DONE;
                end
            end
            S_PREP2:
            begin
                cmd.ld_second = 1'b1;
                state_next    = S_WALK2;
            end
            S_WALK2:
            begin
                cmd.walk_up = 1'b1;
                if (!status.up_more)
                begin
                    state_next = S_DONE;
                end
            end
            S_QWALK:
            begin
                cmd.walk_down = 1'b1;
                if (!status.down_more)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.ld_prod = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                // Wait for the result register to be free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Result register valid: set on load, cleared by a transfer.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ src/fra_datapath.sv @@
// Datapath: size register, request capture, walk position, tree RAMs and result.
`default_nettype none

module fra_datapath
    import fra_pkg::*;
#(
    parameter int MAX_POSITIONS = FRA_MAX_POSITIONS
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    input  wire logic [POS_W-1:0]  cfg_size,
    input  wire logic              req_mode,
    input  wire logic [POS_W-1:0]  req_first,
    input  wire logic [POS_W-1:0]  req_last,
    input  wire logic [DATA_W-1:0] req_value,
    input  wire fra_cmd_t          cmd,
    output fra_status_t            status,
    output logic [DATA_W-1:0]      prefix_sum,
    output logic                   bad_request
);

    // RAM address, effective-size and walk-position widths.
    localparam int AW = $clog2(MAX_POSITIONS);
    localparam int PW = $clog2(MAX_POSITIONS + 1);
    localparam int CW = (PW + 1 > POS_W + 1) ? PW + 1 : POS_W + 1;
    localparam logic [CW-1:0] MAX_C   = CW'(MAX_POSITIONS);
    localparam logic [AW-1:0] LAST_AD = AW'(MAX_POSITIONS - 1);

    logic [POS_W-1:0]    size_reg;
    logic                mode_reg;
    logic [POS_W-1:0]    first_reg;
    logic [POS_W-1:0]    last_reg;
    logic [DATA_W-1:0]   value_reg;
    logic [CW-1:0]       pos_reg;
    logic [CW-1:0]       pos_next;
    logic [CW-1:0]       qx_reg;
    logic [DATA_W-1:0]   dv_reg;
    logic [DATA_W-1:0]   wv_reg;
    logic [DATA_W-1:0]   dacc_reg;
    logic [DATA_W-1:0]   wacc_reg;
    logic [DATA_W-1:0]   prod_reg;
    logic [DATA_W-1:0]   prefix_reg;
    logic                bad_reg;
    logic                rmw_reg;
    logic                acc_reg;
    logic [AW-1:0]       wb_addr_reg;
    logic [AW-1:0]       clr_cnt_reg;

    logic [CW-1:0]       size_ext;
    logic [CW-1:0]       n_eff;
    logic [CW-1:0]       first_ext;
    logic [CW-1:0]       last_ext;
    logic [CW-1:0]       p_ext;
    logic [CW-1:0]       qx;
    logic [CW-1:0]       low_bit;
    logic [CW-1:0]       pos_m1;
    logic                bad;
    logic                up_issue;
    logic                down_issue;
    logic [CW-1:0]       mul_a;
    logic [DATA_W-1:0]   mul_b;
    logic [CW+DATA_W-1:0] mul_full;
    logic [DATA_W-1:0]   mul_lo;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [DATA_W-1:0]   wr_data_d;
    logic [DATA_W-1:0]   wr_data_w;
    logic [DATA_W-1:0]   rd_data_d;
    logic [DATA_W-1:0]   rd_data_w;

    // Size register, written by a configuration transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else if (cfg_valid)
        begin
            size_reg <= cfg_size;
        end
    end

    // Effective size saturated to 1..MAX_POSITIONS.
    assign size_ext = {{(CW - POS_W){1'b0}}, size_reg};
    always_comb
    begin
        if (size_ext == '0)
        begin
            n_eff = CW'(1);
        end
        else if (size_ext > MAX_C)
        begin
            n_eff = MAX_C;
        end
        else
        begin
            n_eff = size_ext;
        end
    end

    // Request decode: range check, cancel point and clamped query end.
    assign first_ext = {{(CW - POS_W){1'b0}}, first_reg};
    assign last_ext  = {{(CW - POS_W){1'b0}}, last_reg};
    assign p_ext     = last_ext + CW'(1);
    assign qx        = (last_ext > n_eff) ? n_eff : last_ext;
    assign bad       = (first_reg == '0) || (first_reg > last_reg) || (first_ext > n_eff);

    // Walk step: lowest set bit of the position and the read issue conditions.
    assign low_bit    = pos_reg & (~pos_reg + CW'(1));
    assign pos_m1     = pos_reg - CW'(1);
    assign up_issue   = cmd.walk_up && (pos_reg != '0) && (pos_reg <= n_eff);
    assign down_issue = cmd.walk_down && (pos_reg != '0);

    assign status.clr_done    = (clr_cnt_reg == LAST_AD);
    assign status.is_query    = mode_reg;
    assign status.bad_req     = bad;
    assign status.need_second = (last_ext < n_eff);
    assign status.up_more     = (pos_reg != '0) && (pos_reg <= n_eff);
    assign status.down_more   = (pos_reg != '0);

    // Shared multiplier: position times value, or (x+1) times the difference prefix.
    always_comb
    begin
        if (cmd.ld_first)
        begin
            mul_a = first_ext;
        end
        else if (cmd.ld_second)
        begin
            mul_a = p_ext;
        end
        else
        begin
            mul_a = qx_reg + CW'(1);
        end
        mul_b = cmd.ld_prod ? dacc_reg : value_reg;
    end
    assign mul_full = mul_a * mul_b;
    assign mul_lo   = mul_full[DATA_W-1:0];

    // Walk position.
    always_comb
    begin
        pos_next = pos_reg;
        if (cmd.ld_first)
        begin
            pos_next = first_ext;
        end
        else if (cmd.ld_second)
        begin
            pos_next = p_ext;
        end
        else if (cmd.ld_query)
        begin
            pos_next = qx;
        end
        else if (up_issue)
        begin
            pos_next = pos_reg + low_bit;
        end
        else if (down_issue)
        begin
            pos_next = pos_reg - low_bit;
        end
    end

    // Request payload, step values, accumulators and product.
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            mode_reg  <= req_mode;
            first_reg <= req_first;
            last_reg  <= req_last;
            value_reg <= req_value;
        end
        pos_reg <= pos_next;
        if (cmd.ld_query)
        begin
            qx_reg <= qx;
        end
        if (cmd.ld_first)
        begin
            dv_reg <= value_reg;
            wv_reg <= mul_lo;
        end
        else if (cmd.ld_second)
        begin
            dv_reg <= DATA_W'(0) - value_reg;
            wv_reg <= DATA_W'(0) - mul_lo;
        end
        if (cmd.ld_query)
        begin
            dacc_reg <= '0;
            wacc_reg <= '0;
        end
        else if (acc_reg)
        begin
            dacc_reg <= dacc_reg + rd_data_d;
            wacc_reg <= wacc_reg + rd_data_w;
        end
        if (cmd.ld_prod)
        begin
            prod_reg <= mul_lo;
        end
        if (rd_en)
        begin
            wb_addr_reg <= rd_addr;
        end
        if (cmd.out_load)
        begin
            prefix_reg <= mode_reg ? (prod_reg - wacc_reg) : '0;
            bad_reg    <= !mode_reg && bad;
        end
    end

    // Pending write-back and accumulate flags, and the clearing address.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rmw_reg     <= 1'b0;
            acc_reg     <= 1'b0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            rmw_reg <= up_issue;
            acc_reg <= down_issue;
            if (cmd.clr_en)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
        end
    end

    // RAM port selection: clearing pass, or write-back of the node read last cycle.
    assign rd_en     = up_issue || down_issue;
    assign rd_addr   = pos_m1[AW-1:0];
    assign wr_en     = cmd.clr_en || rmw_reg;
    assign wr_addr   = cmd.clr_en ? clr_cnt_reg : wb_addr_reg;
    assign wr_data_d = cmd.clr_en ? '0 : (rd_data_d + dv_reg);
    assign wr_data_w = cmd.clr_en ? '0 : (rd_data_w + wv_reg);

    fra_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_POSITIONS)
    ) u_diff_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data_d),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data_d)
    );

    fra_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_POSITIONS)
    ) u_wdiff_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data_w),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data_w)
    );

    assign prefix_sum  = prefix_reg;
    assign bad_request = bad_reg;

endmodule

`default_nettype wire

@@ src/fra_checker.sv @@
// Port-level checker for the Fenwick range-add block, bound to the top level.
`default_nettype none

module fra_checker
    import fra_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              req_valid,
    input wire logic              req_ready,
    input wire logic              rsp_valid,
    input wire logic              rsp_ready,
    input wire logic [DATA_W-1:0] rsp_prefix_sum,
    input wire logic              rsp_bad_request
);

    logic [1:0] pending_reg;
    logic       req_xfer;
    logic       rsp_xfer;

    assign req_xfer = req_valid && req_ready;
    assign rsp_xfer = rsp_valid && rsp_ready;

    // Requests taken whose results have not yet been transferred.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + {1'b0, req_xfer} - {1'b0, rsp_xfer};
        end
    end

    // A result is only offered for a request that was taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (pending_reg != 2'd0))
    else $error("result offered with no request outstanding");

    // At most one request is at work beside a waiting result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg == 2'd2) |-> !req_ready)
    else $error("request taken while a result waits and another is at work");

    // A rejected update carries a zero sum.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_bad_request) |-> (rsp_prefix_sum == '0))
    else $error("rejected update with nonzero prefix sum");

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(rsp_prefix_sum) && $stable(rsp_bad_request)))
    else $error("stalled result changed");

endmodule

bind fenwick_range_add_prefix_sum fra_checker u_fra_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_prefix_sum  (rsp.prefix_sum),
    .rsp_bad_request (rsp.bad_request)
);

`default_nettype wire

@@ tb/fra_tb_pkg.sv @@
// Operation codes and the result record shared by the Fenwick testbench files.
package fra_tb_pkg;

    // Request kinds carried in the mode field.
    typedef enum logic {
        OP_RANGE_ADD    = 1'b0,
        OP_PREFIX_QUERY = 1'b1
    } fra_op_e;

    // One result as it should appear on the response channel.
    typedef struct packed {
        logic signed [fra_pkg::DATA_W-1:0] prefix_sum;
        logic                              bad_request;
    } fra_result_t;

endpackage

@@ tb/fenwick_sum_checker.sv @@
// Checker that mirrors both Fenwick trees and compares every response transfer.
module fenwick_sum_checker (
    input  logic        clk,
    input  logic        rst_n,
    fra_cfg_if          cfg,
    fra_req_if          req,
    fra_rsp_if          rsp,
    output int unsigned mismatches,
    output int unsigned outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import fra_pkg::*;
    import fra_tb_pkg::*;

    // Mirrored tree contents and the live size register.
    logic [DATA_W-1:0] diff_nodes     [1:FRA_MAX_POSITIONS];
    logic [DATA_W-1:0] weighted_nodes [1:FRA_MAX_POSITIONS];
    logic [POS_W-1:0]  size_reg;
    fra_result_t       expected_sums [$];

    // The size register saturates to 1..capacity when the trees are walked.
    function automatic int unsigned span_size();
        if (size_reg == '0)
        begin
            return 1;
        end
        if (size_reg > FRA_MAX_POSITIONS)
        begin
            return FRA_MAX_POSITIONS;
        end
        return size_reg;
    endfunction

    function automatic int unsigned lowest_bit(input int unsigned x);
        return x & (~x + 1);
    endfunction

    // Adds a value along the update path of one tree, stopping past the live size.
    task automatic tree_bump(input bit weighted, input int unsigned pos, input int unsigned n,
                             input logic [DATA_W-1:0] v);
        while (pos >= 1 && pos <= n)
        begin
            if (weighted)
            begin
                weighted_nodes[pos] += v;
            end
            else
            begin
                diff_nodes[pos] += v;
            end
            pos += lowest_bit(pos);
        end
    endtask

    // Prefix sum of elements 1..x: (x+1) times the difference prefix minus the weighted one.
    function automatic logic [DATA_W-1:0] prefix_total(input int unsigned x);
        logic [DATA_W-1:0] d;
        logic [DATA_W-1:0] w;
        int unsigned       p;
        d = '0;
        w = '0;
        p = x;
        while (p != 0)
        begin
            d += diff_nodes[p];
            w += weighted_nodes[p];
            p -= lowest_bit(p);
        end
        return (DATA_W'(x) + 1) * d - w;
    endfunction

    // Applies one request to the mirrored trees and works out the result it causes.
    task automatic predict_result(input fra_op_e op, input logic [POS_W-1:0] first,
                                  input logic [POS_W-1:0] last, input logic [DATA_W-1:0] v,
                                  output fra_result_t res);
        int unsigned n;
        int unsigned p;
        n = span_size();
        res = '0;
        if (op == OP_PREFIX_QUERY)
        begin
            res.prefix_sum = prefix_total((last > n) ? n : last);
        end
        else if (first == 0 || first > last || first > n)
        begin
            res.bad_request = 1'b1;
        end
        else
        begin
            tree_bump(1'b0, first, n, v);
            tree_bump(1'b1, first, n, DATA_W'(first) * v);
            // A range that reaches the size needs no cancelling entry.
            if (last < n)
            begin
                p = last + 1;
                tree_bump(1'b0, p, n, -v);
                tree_bump(1'b1, p, n, -(DATA_W'(p) * v));
            end
        end
    endtask

    // Watch all three channels at each edge: register writes, results, then requests.
    always @(posedge clk or negedge rst_n)
    begin : watch
        fra_result_t want;
        fra_result_t got;
        int unsigned errs;
        errs = 0;
        if (!rst_n)
        begin
            for (int i = 1; i <= FRA_MAX_POSITIONS; i++)
            begin
                diff_nodes[i] = '0;
                weighted_nodes[i] = '0;
            end
            size_reg = SIZE_RESET;
            expected_sums.delete();
            mismatches <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                size_reg = cfg.size_in_use;
            end

            if (rsp.valid && rsp.ready)
            begin
                got.prefix_sum = rsp.prefix_sum;
                got.bad_request = rsp.bad_request;
                if (expected_sums.size() == 0)
                begin
                    $error("result transfer with nothing expected: prefix_sum %0d, bad_request %0b",
                           got.prefix_sum, got.bad_request);
                    errs++;
                end
                else
                begin
                    want = expected_sums.pop_front();
                    if (got.prefix_sum !== want.prefix_sum)
                    begin
                        $error("prefix_sum mismatch: expected %0d, actual %0d",
                               want.prefix_sum, got.prefix_sum);
                        errs++;
                    end
                    if (got.bad_request !== want.bad_request)
                    begin
                        $error("bad_request mismatch: expected %0b, actual %0b",
                               want.bad_request, got.bad_request);
                        errs++;
                    end
                end
            end

            if (req.valid && req.ready)
            begin
                predict_result(fra_op_e'(req.mode), req.first_pos, req.last_pos, req.add_value,
                               want);
                expected_sums.push_back(want);
            end

            mismatches <= mismatches + errs;
            outstanding <= expected_sums.size();
        end
    end

endmodule

@@ tb/fenwick_range_add_prefix_sum_tb.sv @@
// Top of the Fenwick range-add testbench: clock, reset, stimulus and the verdict.
module fenwick_range_add_prefix_sum_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fra_pkg::*;
    import fra_tb_pkg::*;

    localparam int          RANDOM_PHASES   = 6;
    localparam int          ITEMS_PER_PHASE = 88;
    localparam int          HOLD_CYCLES     = 400;
    localparam int          DRAIN_LIMIT     = 20000;
    localparam int          SETTLE_CYCLES   = 60;
    localparam int unsigned POS_ALL         = (1 << POS_W) - 1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          hold_resp;
    int unsigned live_size;
    int unsigned mismatches;
    int unsigned outstanding;

    fra_cfg_if cfg_ch ();
    fra_req_if req_ch ();
    fra_rsp_if rsp_ch ();

    fenwick_range_add_prefix_sum dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    fenwick_sum_checker sum_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_ch),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #6 clk = ~clk;

    // Hard stop in case the block hangs.
    initial
    begin : watchdog
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Response side: random back-pressure, plus one long hold-off on request.
    initial
    begin : rsp_drain
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_resp)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_resp = 1'b0;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offers one request after a random gap and waits for its transfer.
    task automatic send_req(input fra_op_e op, input logic [POS_W-1:0] first,
                            input logic [POS_W-1:0] last, input logic [DATA_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.mode <= op;
        req_ch.first_pos <= first;
        req_ch.last_pos <= last;
        req_ch.add_value <= value;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
    endtask

    // Stops offering and waits until every expected result has come back.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (outstanding != 0);
    endtask

    // Writes the size register once the block is idle.
    task automatic write_size(input logic [POS_W-1:0] value);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.size_in_use <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (value == 0)
        begin
            live_size = 1;
        end
        else if (value > FRA_MAX_POSITIONS)
        begin
            live_size = FRA_MAX_POSITIONS;
        end
        else
        begin
            live_size = value;
        end
    endtask

    // One random request: mostly well-formed queries and adds, some rejected ranges.
    task automatic random_item();
        int unsigned       pick;
        int unsigned       first;
        int unsigned       last;
        int                small_val;
        logic [DATA_W-1:0] value;
        pick = $urandom_range(99);
        small_val = int'($urandom_range(2000)) - 1000;
        value = ($urandom_range(1) == 1) ? {$urandom, $urandom} : DATA_W'(small_val);
        if (pick < 45)
        begin
            last = ($urandom_range(9) == 0) ? $urandom_range(POS_ALL) : $urandom_range(live_size);
            send_req(OP_PREFIX_QUERY, POS_W'($urandom), POS_W'(last), value);
        end
        else if (pick < 90)
        begin
            first = $urandom_range(live_size, 1);
            if ($urandom_range(7) == 0)
            begin
                last = $urandom_range(POS_ALL, first);
            end
            else
            begin
                last = $urandom_range(live_size, first);
            end
            send_req(OP_RANGE_ADD, POS_W'(first), POS_W'(last), value);
        end
        else
        begin
            case ($urandom_range(2))
                0:
                begin
                    first = 0;
                    last = $urandom_range(POS_ALL);
                end
                1:
                begin
                    first = $urandom_range(live_size, 1);
                    last = $urandom_range(first - 1);
                end
                default:
                begin
                    first = $urandom_range(POS_ALL, live_size + 1);
                    last = $urandom_range(POS_ALL);
                end
            endcase
            send_req(OP_RANGE_ADD, POS_W'(first), POS_W'(last), value);
        end
    endtask

    // Main sequence: reset, directed corners, then random phases under several sizes.
    initial
    begin : stimulus
        logic [POS_W-1:0] phase_size;
        int               waited;
        cfg_ch.valid = 1'b0;
        cfg_ch.size_in_use = '0;
        req_ch.valid = 1'b0;
        req_ch.mode = OP_RANGE_ADD;
        req_ch.first_pos = '0;
        req_ch.last_pos = '0;
        req_ch.add_value = '0;
        send_idle_pct = 30;
        recv_idle_pct = 83;
        hold_resp = 1'b0;
        live_size = FRA_MAX_POSITIONS;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed corners at full size.
        write_size(SIZE_RESET);
        send_req(OP_PREFIX_QUERY, '0, '0, '0);
        send_req(OP_PREFIX_QUERY, '0, 11'd1024, '0);
        send_req(OP_RANGE_ADD, 11'd1, 11'd1024, 64'h7FFF_FFFF_FFFF_FFFF);
        send_req(OP_RANGE_ADD, 11'd1, 11'd1, 64'h8000_0000_0000_0000);
        send_req(OP_PREFIX_QUERY, '0, 11'd1, '0);
        send_req(OP_PREFIX_QUERY, '0, 11'd1024, '0);
        // Rejected ranges: zero start, reversed range, start past the size.
        send_req(OP_RANGE_ADD, '0, 11'd5, 64'd77);
        send_req(OP_RANGE_ADD, 11'd9, 11'd8, 64'd77);
        send_req(OP_RANGE_ADD, 11'h7FF, 11'h7FF, '1);
        send_req(OP_RANGE_ADD, 11'd1, 11'd0, 64'd3);
        // Range end past the size, and a query end past the size.
        send_req(OP_RANGE_ADD, 11'd1000, 11'h7FF, {$urandom, $urandom});
        send_req(OP_PREFIX_QUERY, 11'h7FF, 11'h7FF, '1);
        send_req(OP_RANGE_ADD, 11'd3, 11'd700, '1);
        send_req(OP_PREFIX_QUERY, '0, 11'd700, '0);
        send_req(OP_PREFIX_QUERY, '0, 11'd2, '0);
        send_req(OP_RANGE_ADD, 11'd1024, 11'd1024, 64'd12345);
        send_req(OP_PREFIX_QUERY, '0, 11'd1023, '0);
        send_req(OP_PREFIX_QUERY, '0, 11'd1024, '0);
        // Cancelling entry lands on the last position.
        send_req(OP_RANGE_ADD, 11'd512, 11'd1023, {$urandom, $urandom});
        send_req(OP_PREFIX_QUERY, POS_W'($urandom), 11'd1023, {$urandom, $urandom});
        send_req(OP_PREFIX_QUERY, POS_W'($urandom), 11'd1024, {$urandom, $urandom});

        // Random phases: size extremes and a mid value, three idling regimes.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: phase_size = 11'd1024;
                1: phase_size = 11'd1;
                2: phase_size = 11'h7FF;
                3: phase_size = 11'd0;
                4: phase_size = POS_W'($urandom_range(1023, 2));
                default: phase_size = 11'd1024;
            endcase
            write_size(phase_size);
            if (ph < 2)
            begin
                send_idle_pct = 30;
                recv_idle_pct = 83;
            end
            else if (ph < 4)
            begin
                send_idle_pct = 83;
                recv_idle_pct = 30;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (ph == 0 && k == 40)
                begin
                    wait_drained();
                end
                if (ph == 5 && k == 20)
                begin
                    hold_resp = 1'b1;
                end
                random_item();
            end
        end
        req_ch.valid <= 1'b0;

        // Let the last results come back, then give the verdict.
        waited = 0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (outstanding != 0 && waited < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (outstanding != 0)
        begin
            $error("%0d expected results never arrived", outstanding);
        end
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/fra_pkg.sv
src/fra_req_if.sv
src/fra_rsp_if.sv
src/fra_cfg_if.sv
src/fra_ram.sv
src/fra_ctrl.sv
src/fra_datapath.sv
src/fenwick_range_add_prefix_sum.sv
src/fra_checker.sv
tb/fra_tb_pkg.sv
tb/fenwick_sum_checker.sv
tb/fenwick_range_add_prefix_sum_tb.sv
